// ----- hdl/i2f_pkg.sv -----
package i2f_pkg;

  localparam int unsigned IntW     = 32;
  localparam int unsigned SignPos  = 31;
  localparam int unsigned FracBits = 23;
  localparam int unsigned LeadW    = 5;
  localparam int unsigned ExpW     = 8;

  localparam logic [ExpW-1:0] ExpBias = 8'd127;
  // largest exponent a 32-bit integer can reach: 2^31
  localparam logic [ExpW-1:0] ExpMax  = 8'd158;

  // guard bit position inside the normalized word
  localparam int unsigned GuardPos = SignPos - FracBits - 1;

  // stage 1 -> stage 2: sign and magnitude
  typedef struct packed {
    logic            neg;
    logic            zero;
    logic [IntW-1:0] mag;
  } i2f_abs_t;

  // stage 3 -> round stage: leading one moved to bit 31
  typedef struct packed {
    logic             neg;
    logic             zero;
    logic [LeadW-1:0] lead;
    logic [IntW-1:0]  norm;
  } i2f_norm_t;

  // position of the highest set bit, 0 when none
  function automatic logic [LeadW-1:0] lead_one(input logic [IntW-1:0] v);
    logic [LeadW-1:0] pos;
    pos = '0;
    for (int k = 0; k < IntW; k++) begin
      if (v[k]) begin
        pos = LeadW'(k);
      end
    end
    return pos;
  endfunction

endpackage

// ----- hdl/i2f_normalize.sv -----
module i2f_normalize (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  i2f_pkg::i2f_abs_t  up_data,
  output logic               dn_valid,
  input  logic               dn_ready,
  output i2f_pkg::i2f_norm_t dn_data
);
  import i2f_pkg::*;

  // stage 2: leading-one position
  logic             s2_valid_r;
  logic             s2_neg_r;
  logic             s2_zero_r;
  logic [LeadW-1:0] s2_lead_r;
  logic [IntW-1:0]  s2_mag_r;
  logic             s2_ready;

  // stage 3: normalized magnitude
  logic             s3_valid_r;
  i2f_norm_t        s3_data_r;
  i2f_norm_t        s3_data_nxt;
  logic             s3_ready;

  assign s3_ready = !s3_valid_r || dn_ready;
  assign s2_ready = !s2_valid_r || s3_ready;
  assign up_ready = s2_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && up_valid) begin
      s2_neg_r  <= up_data.neg;
      s2_zero_r <= up_data.zero;
      s2_mag_r  <= up_data.mag;
      s2_lead_r <= lead_one(up_data.mag);
    end
  end

  always_comb begin
    s3_data_nxt.neg  = s2_neg_r;
    s3_data_nxt.zero = s2_zero_r;
    s3_data_nxt.lead = s2_lead_r;
    s3_data_nxt.norm = s2_mag_r << (LeadW'(SignPos) - s2_lead_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (s3_ready) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s2_valid_r) begin
      s3_data_r <= s3_data_nxt;
    end
  end

  assign dn_valid = s3_valid_r;
  assign dn_data  = s3_data_r;

endmodule

// ----- hdl/int32_to_float32_converter_top.sv -----
// Path: an accepted input passes the stage 1, stage 2, stage 3 and output registers in turn
// before out_tvalid rises, holding wherever a later stage is full (four register stages).
// Throughput: one transaction per cycle; each stage holds when the one after is full.
// Stages: sign/magnitude, leading-one detect, normalize shift, round into output register.
// Reset: rst_n synchronous, active low, clears all stage valid bits; payload is not reset.
module int32_to_float32_converter_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic signed [31:0] in_tdata,   // [31:0] int_value
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [31:0]        out_tdata   // [31:0] float_word
);
  import i2f_pkg::*;

  // stage 1: sign and magnitude
  logic      s1_valid_r;
  i2f_abs_t  s1_data_r;
  i2f_abs_t  s1_data_nxt;
  logic      s1_ready;

  // normalize segment output
  logic      nm_valid;
  logic      nm_ready;
  i2f_norm_t nm_data;

  // round stage / output register
  logic            out_valid_r;
  logic [IntW-1:0] out_data_r;
  logic [IntW-1:0] out_data_nxt;
  logic            out_ready;

  logic [FracBits-1:0] frac;
  logic                guard;
  logic                sticky;
  logic                round_up;
  logic [ExpW-1:0]     exp_biased;

  assign out_ready = !out_valid_r || out_tready;
  assign in_tready = s1_ready;

  // stage 1: magnitude; the most negative value wraps to 2^31 as unsigned
  always_comb begin
    s1_data_nxt.neg  = in_tdata[SignPos];
    s1_data_nxt.zero = (in_tdata == '0);
    s1_data_nxt.mag  = in_tdata[SignPos] ? (IntW'(0) - IntW'(in_tdata)) : IntW'(in_tdata);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_tvalid) begin
      s1_data_r <= s1_data_nxt;
    end
  end

  // stages 2 and 3
  i2f_normalize u_normalize (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid_r),
    .up_ready (s1_ready),
    .up_data  (s1_data_r),
    .dn_valid (nm_valid),
    .dn_ready (nm_ready),
    .dn_data  (nm_data)
  );

  assign nm_ready = out_ready;

  // stage 4: round to nearest even; hidden bit sits at bit 31 of norm
  always_comb begin
    frac       = nm_data.norm[SignPos-1 -: FracBits];
    guard      = nm_data.norm[GuardPos];
    sticky     = |nm_data.norm[GuardPos-1:0];
    round_up   = guard && (sticky || nm_data.norm[GuardPos+1]);
    exp_biased = ExpW'(nm_data.lead) + ExpBias;
    // carry out of the fraction bumps the exponent through this add
    out_data_nxt = {nm_data.neg, exp_biased, frac} + IntW'(round_up);
    if (nm_data.zero) begin
      out_data_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= nm_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && nm_valid) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- hdl/i2f_checker.sv -----
module i2f_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);
  import i2f_pkg::*;

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed while stalled");

  // zero exponent only for +0
  a_zero_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[30:23] == '0) |-> (out_tdata == '0))
    else $error("denormal or negative zero produced");

  // exponent range of a 32-bit integer
  a_exp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata != '0) |->
      (out_tdata[30:23] >= ExpBias) && (out_tdata[30:23] <= ExpMax))
    else $error("exponent out of range");

  // 2^31 magnitude is exact
  a_top_exact: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[30:23] == ExpMax) |-> (out_tdata[22:0] == '0))
    else $error("nonzero fraction at top exponent");

  // no stall downstream: the accepted input shows up as out_tvalid
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && out_tready ##1 out_tready ##1 out_tready ##1 out_tready
      |=> out_tvalid)
    else $error("result missing after pipeline latency");

endmodule

bind int32_to_float32_converter_top i2f_checker u_i2f_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
